### rtl/hsc_pkg.sv
// Shared types, constants and helper functions for the Hamming SEC codec.
package hsc_pkg;

  localparam int WordW    = 63;
  localparam int LenW     = 6;
  localparam int ParW     = 3;
  localparam int SynW     = 6;
  localparam int MaxData  = 57;
  localparam int MaxParity = 7;

  localparam logic [LenW-1:0] DataBitsReset = LenW'(4);
  localparam logic [ParW-1:0] ParityReset   = ParW'(3);

  typedef enum logic {
    CMD_ENCODE  = 1'b0,
    CMD_CORRECT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [WordW-1:0]  word;
    logic [LenW-1:0]   len;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [SynW-1:0]   syndrome;
    logic              out_of_range;
  } result_t;

  // Clamp a written data length into 1..MaxData.
  function automatic logic [LenW-1:0] clamp_data_bits(logic [LenW-1:0] m);
    logic [LenW-1:0] r;
    r = m;
    if (m == '0) r = LenW'(1);
    if (m > LenW'(MaxData)) r = LenW'(MaxData);
    return r;
  endfunction

  // Least p with 2^p >= m + p + 1 (p runs up to 7 at most).
  function automatic logic [ParW-1:0] parity_for(logic [LenW-1:0] m);
    logic [ParW-1:0] p;
    logic [7:0]      need;
    logic [7:0]      cap;
    p = ParW'(1);
    for (int s = 1; s < MaxParity; s++) begin
      need = 8'(m) + 8'(p) + 8'd1;
      cap  = 8'(1) << p;
      if (p == ParW'(s) && cap < need) p = ParW'(s + 1);
    end
    return p;
  endfunction

  // Data index carried at codeword position k (k not a power of two):
  // the positions up to k that are powers of two number clog2(k + 1).
  function automatic int data_index(int k);
    return k - $clog2(k + 1) - 1;
  endfunction

  function automatic bit is_pow2(int k);
    return (k & (k - 1)) == 0;
  endfunction

  // Even-parity checks: check i covers the positions whose index has bit i set.
  function automatic logic [SynW-1:0] syndrome_of(logic [WordW-1:0] w);
    logic [SynW-1:0] syn;
    logic [SynW-1:0] pos;
    syn = '0;
    for (int k = 1; k <= WordW; k++) begin
      pos = SynW'(k);
      for (int i = 0; i < SynW; i++) begin
        if (pos[i]) syn[i] = syn[i] ^ w[k-1];
      end
    end
    return syn;
  endfunction

endpackage

### rtl/hsc_datapath.sv
// Combinational encode and check/correct logic for one codeword.
module hsc_datapath (
  input  hsc_pkg::item_t                  item,
  input  logic [hsc_pkg::LenW-1:0]        data_bits,
  input  logic [hsc_pkg::ParW-1:0]        parity_count,
  output hsc_pkg::result_t                result
);

  logic [hsc_pkg::WordW-1:0] spread;
  logic [hsc_pkg::WordW-1:0] len_mask;
  logic [hsc_pkg::WordW-1:0] enc_word;
  logic [hsc_pkg::WordW-1:0] rx_word;
  logic [hsc_pkg::WordW-1:0] fix_word;
  logic [hsc_pkg::SynW-1:0]  par_mask;
  logic [hsc_pkg::SynW-1:0]  enc_syn;
  logic [hsc_pkg::SynW-1:0]  rx_syn;
  logic [hsc_pkg::SynW-1:0]  flip_pos;
  logic                      rx_far;

  // Scatter data bits to the non-power-of-two positions; drop those at or above m.
  for (genvar k = 1; k <= hsc_pkg::WordW; k++) begin : g_pos
    if (hsc_pkg::is_pow2(k)) begin : g_par
      assign spread[k-1] = 1'b0;
    end else begin : g_dat
      assign spread[k-1] = item.word[hsc_pkg::data_index(k)] &
                           (hsc_pkg::LenW'(hsc_pkg::data_index(k)) < data_bits);
    end
    assign len_mask[k-1] = hsc_pkg::LenW'(k - 1) < item.len;
  end

  // Keep only the p checks in use.
  assign par_mask = ~(hsc_pkg::SynW'(6'h3F) << parity_count);

  assign enc_syn = hsc_pkg::syndrome_of(spread) & par_mask;

  always_comb begin
    enc_word = spread;
    for (int i = 0; i < hsc_pkg::SynW; i++) begin
      enc_word[(1 << i) - 1] = enc_syn[i];
    end
  end

  assign rx_word  = item.word & len_mask;
  assign rx_syn   = hsc_pkg::syndrome_of(rx_word) & par_mask;
  assign rx_far   = rx_syn > item.len;
  assign flip_pos = rx_syn - hsc_pkg::SynW'(1);

  always_comb begin
    fix_word = rx_word;
    if (rx_syn != '0 && !rx_far) begin
      fix_word = rx_word ^ (hsc_pkg::WordW'(1) << flip_pos);
    end
  end

  always_comb begin
    case (item.command)
      hsc_pkg::CMD_CORRECT: begin
        result.word         = fix_word;
        result.syndrome     = rx_syn;
        result.out_of_range = (rx_syn != '0) && rx_far;
      end
      default: begin
        result.word         = enc_word;
        result.syndrome     = '0;
        result.out_of_range = 1'b0;
      end
    endcase
  end

endmodule

### rtl/hamming_sec_codec_core.sv
// Top level of the Hamming SEC codec: input register, codec logic, result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_ready  | command, data_word, received_length
//   out      | out_valid / out_ready| result_word, syndrome, parity_count,
//            |                      | position_out_of_range
//   config   | cfg_we               | cfg_wdata (data_bits)
//
// One beat in and one beat out per cycle when the output is not stalled.
// The input register feeds the encode/correct logic, which loads the result
// register. The input register advances when empty or when the result register can
// move; a stall on out_ready holds the result register and a full input register, and
// in_ready drops only while both stages are full. rst clears the stage valids and loads
// data_bits = 4 and a parity count of 3. Write cfg_we only while no beat is in flight.
module hamming_sec_codec_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hsc_pkg::LenW-1:0]    cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [hsc_pkg::WordW-1:0]   data_word,
  input  logic [hsc_pkg::LenW-1:0]    received_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsc_pkg::WordW-1:0]   result_word,
  output logic [hsc_pkg::SynW-1:0]    syndrome,
  output logic [hsc_pkg::ParW-1:0]    parity_count,
  output logic                        position_out_of_range
);

  // Configuration: clamped data length and its parity count, set on write.
  logic [hsc_pkg::LenW-1:0] data_bits;
  logic [hsc_pkg::LenW-1:0] data_bits_next;
  logic [hsc_pkg::ParW-1:0] par_cnt;

  assign data_bits_next = hsc_pkg::clamp_data_bits(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= hsc_pkg::DataBitsReset;
      par_cnt   <= hsc_pkg::ParityReset;
    end else if (cfg_we) begin
      data_bits <= data_bits_next;
      par_cnt   <= hsc_pkg::parity_for(data_bits_next);
    end
  end

  // Stage control: the result register advances when empty or taken;
  // the input register advances when empty or when it can pass its beat on.
  logic           stage_valid;
  hsc_pkg::item_t stage_item;
  hsc_pkg::result_t dp_result;
  logic           out_adv;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) stage_valid <= in_valid;
      if (out_adv)  out_valid   <= stage_valid;
    end
  end

  // Capture the incoming beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.command <= hsc_pkg::cmd_t'(command);
      stage_item.word    <= data_word;
      stage_item.len     <= received_length;
    end
  end

  hsc_datapath u_datapath (
    .item         (stage_item),
    .data_bits    (data_bits),
    .parity_count (par_cnt),
    .result       (dp_result)
  );

  // Result register: load when the stage holds a beat and the output can move.
  always_ff @(posedge clk) begin
    if (out_adv && stage_valid) begin
      result_word           <= dp_result.word;
      syndrome              <= dp_result.syndrome;
      parity_count          <= par_cnt;
      position_out_of_range <= dp_result.out_of_range;
    end
  end

endmodule

### rtl/hsc_checker.sv
// Port-level checks for the Hamming SEC codec, bound to the top level.
module hsc_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hsc_pkg::WordW-1:0]   result_word,
  input logic [hsc_pkg::SynW-1:0]    syndrome,
  input logic [hsc_pkg::ParW-1:0]    parity_count,
  input logic                        position_out_of_range
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Parity count stays within 2..6.
  a_par_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (parity_count >= hsc_pkg::ParW'(2) && parity_count <= hsc_pkg::ParW'(6)))
    else $error("parity_count out of range");

  // A flagged position always comes with a nonzero syndrome.
  a_flag_syn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && position_out_of_range) |-> syndrome != '0)
    else $error("out-of-range flag with zero syndrome");

  // Syndrome never uses checks beyond the parity count.
  a_syn_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (syndrome >> parity_count) == '0)
    else $error("syndrome wider than parity count");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_word) && $stable(syndrome)))
    else $error("stalled result changed");

endmodule

bind hamming_sec_codec_core hsc_port_checks u_hsc_port_checks (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .result_word           (result_word),
  .syndrome              (syndrome),
  .parity_count          (parity_count),
  .position_out_of_range (position_out_of_range)
);

### tb/sv/hsc_checker.sv
// Scoreboard for the Hamming SEC codec: predicts every result beat and compares it.
`timescale 1ns / 100ps

module hsc_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hsc_pkg::LenW-1:0]  cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      command,
  input  logic [hsc_pkg::WordW-1:0] data_word,
  input  logic [hsc_pkg::LenW-1:0]  received_length,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [hsc_pkg::WordW-1:0] result_word,
  input  logic [hsc_pkg::SynW-1:0]  syndrome,
  input  logic [hsc_pkg::ParW-1:0]  parity_count,
  input  logic                      position_out_of_range,
  output int                        pending,
  output int                        errors
);

  typedef struct packed {
    logic [hsc_pkg::WordW-1:0] word;
    logic [hsc_pkg::SynW-1:0]  syn;
    logic [hsc_pkg::ParW-1:0]  par;
    logic                      oor;
  } codec_outcome_t;

  codec_outcome_t           outcome_q[$];
  codec_outcome_t           head;
  logic [hsc_pkg::LenW-1:0] data_bits_shadow;

  initial errors = 0;

  // Even parity checks over positions 1..span; check i weighs 2^i.
  function automatic logic [hsc_pkg::SynW-1:0] even_checks(logic [hsc_pkg::WordW-1:0] w,
                                                           int span, int nchk);
    logic [hsc_pkg::SynW-1:0] s;
    s = '0;
    for (int i = 0; i < nchk; i++)
      for (int k = 1; k <= span && k <= hsc_pkg::WordW; k++)
        if (((k >> i) & 1) == 1) s[i] = s[i] ^ w[k-1];
    return s;
  endfunction

  function automatic codec_outcome_t codec_outcome(logic [hsc_pkg::LenW-1:0] dbits,
                                                   hsc_pkg::cmd_t cmd,
                                                   logic [hsc_pkg::WordW-1:0] w,
                                                   logic [hsc_pkg::LenW-1:0] len);
    codec_outcome_t           r;
    logic [hsc_pkg::SynW-1:0] chk;
    int m;
    int p;
    int d;
    m = dbits;
    if (m < 1) m = 1;
    if (m > hsc_pkg::MaxData) m = hsc_pkg::MaxData;
    p = 1;
    while (p < 7 && (1 << p) < m + p + 1) p++;
    r = '0;
    r.par = hsc_pkg::ParW'(p);
    if (cmd == hsc_pkg::CMD_ENCODE) begin
      d = 0;
      for (int k = 1; k <= m + p; k++) begin
        if ((k & (k - 1)) != 0) begin
          r.word[k-1] = w[d];
          d++;
        end
      end
      // parity positions are still clear, so the failing checks give the parity bits
      chk = even_checks(r.word, m + p, p);
      for (int i = 0; i < p; i++)
        if (chk[i]) r.word[(1 << i) - 1] = 1'b1;
    end else begin
      for (int k = 1; k <= len; k++) r.word[k-1] = w[k-1];
      r.syn = even_checks(r.word, len, p);
      if (r.syn != '0) begin
        if (r.syn > len) r.oor = 1'b1;
        else r.word[r.syn - 1] = ~r.word[r.syn - 1];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [hsc_pkg::WordW-1:0] got,
                                 logic [hsc_pkg::WordW-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      outcome_q.delete();
      data_bits_shadow = hsc_pkg::DataBitsReset;
    end else begin
      if (cfg_we) data_bits_shadow = cfg_wdata;
      if (in_valid && in_ready)
        outcome_q.push_back(codec_outcome(data_bits_shadow, hsc_pkg::cmd_t'(command),
                                          data_word, received_length));
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result beat", result_word, '0);
        end else begin
          head = outcome_q.pop_front();
          if (result_word !== head.word) report_mismatch("result_word", result_word, head.word);
          if (syndrome !== head.syn)
            report_mismatch("syndrome", hsc_pkg::WordW'(syndrome), hsc_pkg::WordW'(head.syn));
          if (parity_count !== head.par)
            report_mismatch("parity_count", hsc_pkg::WordW'(parity_count),
                            hsc_pkg::WordW'(head.par));
          if (position_out_of_range !== head.oor)
            report_mismatch("position_out_of_range", hsc_pkg::WordW'(position_out_of_range),
                            hsc_pkg::WordW'(head.oor));
        end
      end
    end
    pending <= outcome_q.size();
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for hamming_sec_codec_core: stimulus, stalls, config phases and verdict.
`timescale 1ns / 100ps

module tb_top;

  // Generous bound: ~1300 beats with stalls, plus phase drains.
  localparam int CycleLimit = 200000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [hsc_pkg::LenW-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      command = 1'b0;
  logic [hsc_pkg::WordW-1:0] data_word = '0;
  logic [hsc_pkg::LenW-1:0]  received_length = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [hsc_pkg::WordW-1:0] result_word;
  logic [hsc_pkg::SynW-1:0]  syndrome;
  logic [hsc_pkg::ParW-1:0]  parity_count;
  logic                      position_out_of_range;

  int outstanding;
  int mismatches;

  // Stimulus-side view of the configuration: codeword length for well-formed words.
  int code_len = 7;
  // When set, neither side idles.
  bit steady = 1'b0;

  hamming_sec_codec_core u_top (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .command               (command),
    .data_word             (data_word),
    .received_length       (received_length),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .result_word           (result_word),
    .syndrome              (syndrome),
    .parity_count          (parity_count),
    .position_out_of_range (position_out_of_range)
  );

  hsc_checker u_chk (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .command               (command),
    .data_word             (data_word),
    .received_length       (received_length),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .result_word           (result_word),
    .syndrome              (syndrome),
    .parity_count          (parity_count),
    .position_out_of_range (position_out_of_range),
    .pending               (outstanding),
    .errors                (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall about 17 percent of the time, never while steady.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 17);
  end

  // Present one beat and hold it until accepted. Called at a rising edge;
  // in_valid gets exactly one assignment per time step.
  task automatic send_beat(hsc_pkg::cmd_t cmd, logic [hsc_pkg::WordW-1:0] w,
                           logic [hsc_pkg::LenW-1:0] len);
    if (!steady) begin
      while ($urandom_range(99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    data_word       <= w;
    received_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every predicted beat has come back, plus
  // margin for the two-stage pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write data_bits while the core is empty and track the codeword length.
  task automatic write_data_bits(logic [hsc_pkg::LenW-1:0] v);
    int m;
    int p;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m = v;
    if (m < 1) m = 1;
    if (m > hsc_pkg::MaxData) m = hsc_pkg::MaxData;
    p = 1;
    while (p < 7 && (1 << p) < m + p + 1) p++;
    code_len = m + p;
  endtask

  // Nearly half are well-formed codewords with zero, one or two flipped bits; the rest
  // are encode beats and raw noise with any length.
  task automatic send_random_item();
    logic [hsc_pkg::WordW-1:0] w;
    logic [hsc_pkg::WordW-1:0] noise;
    logic [hsc_pkg::WordW-1:0] span_mask;
    logic [hsc_pkg::LenW-1:0]  len;
    int sel;
    int x;
    int pos;
    w     = hsc_pkg::WordW'({$urandom(), $urandom()});
    noise = hsc_pkg::WordW'({$urandom(), $urandom()});
    sel   = $urandom_range(99);
    if (sel < 35) begin
      send_beat(hsc_pkg::CMD_ENCODE, w, hsc_pkg::LenW'($urandom_range(63)));
    end else if (sel < 80) begin
      len = ($urandom_range(4) != 0) ? hsc_pkg::LenW'(code_len)
                                     : hsc_pkg::LenW'($urandom_range(63));
      span_mask = (len == hsc_pkg::LenW'(63)) ? '1
                : ((hsc_pkg::WordW'(1) << len) - hsc_pkg::WordW'(1));
      w = w & span_mask;
      // XOR of the set positions is the full syndrome; flipping it seals the word
      x = 0;
      for (int k = 1; k <= len; k++)
        if (w[k-1]) x = x ^ k;
      if (x != 0 && x <= len) w[x-1] = ~w[x-1];
      if (len != 0) begin
        sel = $urandom_range(99);
        if (sel >= 35) begin
          pos = $urandom_range(len, 1);
          w[pos-1] = ~w[pos-1];
        end
        if (sel >= 80) begin
          pos = $urandom_range(len, 1);
          w[pos-1] = ~w[pos-1];
        end
      end
      // junk above the received length must be ignored
      if ($urandom_range(1) == 1) w = w | (noise & ~span_mask);
      send_beat(hsc_pkg::CMD_CORRECT, w, len);
    end else begin
      send_beat(hsc_pkg::CMD_CORRECT, noise, hsc_pkg::LenW'($urandom_range(63)));
    end
  endtask

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk);
      n++;
    end
    $display("FAIL hamming_sec_codec_core");
    $finish;
  end

  initial begin : stimulus
    logic [hsc_pkg::LenW-1:0] v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset length of 4 data bits (7-bit codeword).
    send_beat(hsc_pkg::CMD_ENCODE, '0, '0);
    send_beat(hsc_pkg::CMD_ENCODE, '1, '0);            // data bits above m ignored
    send_beat(hsc_pkg::CMD_ENCODE, hsc_pkg::WordW'(5), '1);  // length ignored in encode
    send_beat(hsc_pkg::CMD_CORRECT, '0, '0);           // zero received length
    send_beat(hsc_pkg::CMD_CORRECT, '1, '0);
    send_beat(hsc_pkg::CMD_CORRECT, '1, '1);           // full 63-bit word
    send_beat(hsc_pkg::CMD_CORRECT, '0, hsc_pkg::LenW'(7));  // clean codeword
    for (int k = 1; k <= 7; k++)                       // single error at each position
      send_beat(hsc_pkg::CMD_CORRECT, hsc_pkg::WordW'(1) << (k - 1), hsc_pkg::LenW'(7));
    // syndrome past the length
    send_beat(hsc_pkg::CMD_CORRECT, hsc_pkg::WordW'(12), hsc_pkg::LenW'(4));
    // clean, excess bits dropped
    send_beat(hsc_pkg::CMD_CORRECT, '1, hsc_pkg::LenW'(7));

    // Config phases: extremes and clamped values first, then other fixed lengths, then random ones.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       v = hsc_pkg::LenW'(1);
        1:       v = hsc_pkg::LenW'(hsc_pkg::MaxData);
        2:       v = hsc_pkg::LenW'(0);
        3:       v = hsc_pkg::LenW'(63);
        4:       v = hsc_pkg::LenW'(2);
        5:       v = hsc_pkg::LenW'(3);
        6:       v = hsc_pkg::LenW'(11);
        7:       v = hsc_pkg::LenW'(26);
        8:       v = hsc_pkg::LenW'(58);
        9:       v = hsc_pkg::LenW'(4);
        default: v = hsc_pkg::LenW'($urandom_range(63));
      endcase
      write_data_bits(v);
      steady = (ph == 6);
      for (int i = 0; i < 103; i++) send_random_item();
    end
    steady = 1'b0;

    settle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS hamming_sec_codec_core");
    end else begin
      $display("FAIL hamming_sec_codec_core");
    end
    $finish;
  end

endmodule
